/* rtl/two_level_page_walk_mmu_assert.svh */
// Assertion macros used by the page walk MMU checker.
`ifndef TWO_LEVEL_PAGE_WALK_MMU_ASSERT_SVH
`define TWO_LEVEL_PAGE_WALK_MMU_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define TLPW_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tlpw same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define TLPW_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tlpw next-cycle check failed");

`endif

/* rtl/tlpw_pkg.sv */
// Types, codes and the control store of the page walk MMU.
package tlpw_pkg;

   localparam int UPC_W = 4;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_PAGING = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PDB = 1'd1;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_NO_DIR = 2'd1;
   localparam logic [1:0] ST_NO_TAB = 2'd2;
   localparam logic [1:0] ST_RANGE = 2'd3;

   localparam int ENT_PRESENT = 0;
   localparam int ENT_ACCESSED = 5;
   localparam int ENT_DIRTY = 6;

   localparam logic [UPC_W-1:0] U_IDLE = 4'd0;
   localparam logic [UPC_W-1:0] U_DISP = 4'd1;
   localparam logic [UPC_W-1:0] U_PHYS = 4'd2;
   localparam logic [UPC_W-1:0] U_DEA = 4'd3;
   localparam logic [UPC_W-1:0] U_DER = 4'd4;
   localparam logic [UPC_W-1:0] U_DEC = 4'd5;
   localparam logic [UPC_W-1:0] U_TEA = 4'd6;
   localparam logic [UPC_W-1:0] U_TER = 4'd7;
   localparam logic [UPC_W-1:0] U_TEC = 4'd8;
   localparam logic [UPC_W-1:0] U_DTA = 4'd9;
   localparam logic [UPC_W-1:0] U_DAT = 4'd10;
   localparam logic [UPC_W-1:0] U_CAP = 4'd11;
   localparam logic [UPC_W-1:0] U_FIN = 4'd12;

   typedef struct packed {
      logic        cmd;
      logic [31:0] vaddr;
      logic [2:0]  nbytes;
      logic [31:0] wdata;
   } req_type;

   typedef struct packed {
      logic [31:0] rdata;
      logic [1:0]  status;
   } rsp_type;

   typedef enum logic [3:0] {
      OP_IDLE,
      OP_DISP,
      OP_PHYS_ADDR,
      OP_DE_ADDR,
      OP_RD_ENT,
      OP_DE_CHK,
      OP_TE_ADDR,
      OP_TE_CHK,
      OP_DATA_ADDR,
      OP_DATA_ACC,
      OP_CAP,
      OP_FIN
   } op_type;

   typedef enum logic [2:0] {
      SQ_NEXT,
      SQ_JUMP,
      SQ_WAIT_IN,
      SQ_DISPATCH,
      SQ_LOOP,
      SQ_WAIT_OUT
   } seq_type;

   typedef struct packed {
      op_type           op;
      seq_type          seq;
      logic [UPC_W-1:0] target;
   } uword_type;

   typedef struct packed {
      op_type op;
      logic   load;
   } ctl_type;

   typedef struct packed {
      logic zero_len;
      logic paging;
      logic fault;
      logic more;
      logic out_free;
   } flags_type;

   function automatic uword_type ucode(input logic [UPC_W-1:0] upc);
      uword_type w;
      case (upc)
         U_IDLE: w = '{OP_IDLE, SQ_WAIT_IN, U_IDLE};
         U_DISP: w = '{OP_DISP, SQ_DISPATCH, U_IDLE};
         U_PHYS: w = '{OP_PHYS_ADDR, SQ_JUMP, U_DAT};
         U_DEA: w = '{OP_DE_ADDR, SQ_NEXT, U_IDLE};
         U_DER: w = '{OP_RD_ENT, SQ_NEXT, U_IDLE};
         U_DEC: w = '{OP_DE_CHK, SQ_NEXT, U_IDLE};
         U_TEA: w = '{OP_TE_ADDR, SQ_NEXT, U_IDLE};
         U_TER: w = '{OP_RD_ENT, SQ_NEXT, U_IDLE};
         U_TEC: w = '{OP_TE_CHK, SQ_NEXT, U_IDLE};
         U_DTA: w = '{OP_DATA_ADDR, SQ_NEXT, U_IDLE};
         U_DAT: w = '{OP_DATA_ACC, SQ_NEXT, U_IDLE};
         U_CAP: w = '{OP_CAP, SQ_LOOP, U_DEA};
         U_FIN: w = '{OP_FIN, SQ_WAIT_OUT, U_IDLE};
         default: w = '{OP_IDLE, SQ_JUMP, U_IDLE};
      endcase
      return w;
   endfunction

endpackage

/* rtl/two_level_page_walk_mmu.sv */
// Top level of the two-level page walk MMU with its internal memory.
//
// A request word (cmd, vaddr, nbytes, wdata) is taken when req_valid is high
// and req_stall is low; one response word (rdata, status) follows on rsp_valid.
// Registers paging_enable (index 0) and page_dir_base (index 1) are written on
// the csr channel, which is always ready and should only be used when idle.
// One request is in flight at a time; req_stall is low only between requests.
// A page-crossing access walks each byte separately, and a fault ends the walk
// early. The microprogram spends one step per address setup, table read and
// check on the single memory port.
// A finished response sits in an output register, so the next request can be
// taken while rsp_stall holds the previous one; the sequencer waits only
// when a new response is ready and the register is still full.
// Reset clears the sequencer, the response valid and both registers; the
// memory contents are not cleared.
module two_level_page_walk_mmu #(
   parameter int MEM_ADDR_BITS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  tlpw_pkg::req_type              req_data,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output tlpw_pkg::rsp_type              rsp_data,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [tlpw_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [31:0]                    csr_wdata
);

   tlpw_pkg::ctl_type   ctl;
   tlpw_pkg::flags_type flags;

   assign csr_ready = 1'b1;

   tlpw_useq u_useq (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .flags    (flags),
      .ctl      (ctl),
      .req_stall(req_stall)
   );

   tlpw_datapath #(
      .MEM_ADDR_BITS(MEM_ADDR_BITS)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .ctl      (ctl),
      .req_data (req_data),
      .rsp_stall(rsp_stall),
      .rsp_valid(rsp_valid),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .flags    (flags)
   );

endmodule

/* rtl/tlpw_bank.sv */
// One byte lane of the physical memory.
module tlpw_bank #(
   parameter int ADDR_BITS = 14
) (
   input  logic                 clock,
   input  logic                 we,
   input  logic [ADDR_BITS-1:0] addr,
   input  logic [7:0]           wd,
   output logic [7:0]           q
);

   logic [7:0] mem [2**ADDR_BITS];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wd;
      end
      q <= mem[addr];
   end

endmodule

/* rtl/tlpw_useq.sv */
// Microprogram sequencer: step counter, control store and branch logic.
module tlpw_useq (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  tlpw_pkg::flags_type flags,
   output tlpw_pkg::ctl_type   ctl,
   output logic                req_stall
);

   logic [tlpw_pkg::UPC_W-1:0] upc_ff;
   logic [tlpw_pkg::UPC_W-1:0] upc_in;
   tlpw_pkg::uword_type        uword;

   assign uword = tlpw_pkg::ucode(upc_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= tlpw_pkg::U_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

   always_comb begin
      upc_in = upc_ff;
      case (uword.seq)
         tlpw_pkg::SQ_WAIT_IN: begin
            if (req_valid) begin
               upc_in = tlpw_pkg::U_DISP;
            end
         end
         tlpw_pkg::SQ_DISPATCH: begin
            if (flags.zero_len) begin
               upc_in = tlpw_pkg::U_FIN;
            end else if (flags.paging) begin
               upc_in = tlpw_pkg::U_DEA;
            end else begin
               upc_in = tlpw_pkg::U_PHYS;
            end
         end
         tlpw_pkg::SQ_JUMP: upc_in = uword.target;
         tlpw_pkg::SQ_NEXT: upc_in = upc_ff + 1'b1;
         tlpw_pkg::SQ_LOOP: upc_in = flags.more ? uword.target : upc_ff + 1'b1;
         tlpw_pkg::SQ_WAIT_OUT: begin
            if (flags.out_free) begin
               upc_in = uword.target;
            end
         end
         default: upc_in = tlpw_pkg::U_IDLE;
      endcase
      if (flags.fault) begin
         upc_in = tlpw_pkg::U_FIN;
      end
      ctl.op = uword.op;
      ctl.load = (uword.seq == tlpw_pkg::SQ_WAIT_IN) && req_valid;
      req_stall = (uword.seq != tlpw_pkg::SQ_WAIT_IN);
   end

endmodule

/* rtl/tlpw_datapath.sv */
// Datapath: request and walk registers, four byte-lane memory, result register.
module tlpw_datapath #(
   parameter int MEM_ADDR_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  tlpw_pkg::ctl_type                  ctl,
   input  tlpw_pkg::req_type                  req_data,
   input  logic                               rsp_stall,
   output logic                               rsp_valid,
   output tlpw_pkg::rsp_type                  rsp_data,
   input  logic                               csr_valid,
   input  logic [tlpw_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [31:0]                        csr_wdata,
   output tlpw_pkg::flags_type                flags
);

   localparam int BANK_BITS = MEM_ADDR_BITS - 2;
   localparam logic [33:0] MEM_SIZE = 34'(1) << MEM_ADDR_BITS;

   logic        cmd_ff, cmd_in;
   logic [31:0] va0_ff, va0_in;
   logic [2:0]  n_ff, n_in;
   logic [31:0] wdata_ff, wdata_in;
   logic        split_ff, split_in;
   logic [1:0]  idx_ff, idx_in;
   logic [31:0] addr_ff, addr_in;
   logic [31:0] ent_ff, ent_in;
   logic [31:0] acc_ff, acc_in;
   logic [1:0]  status_ff, status_in;
   logic        paging_ff, paging_in;
   logic [19:0] pdb_ff, pdb_in;
   logic        rsp_valid_ff, rsp_valid_in;
   tlpw_pkg::rsp_type rsp_data_ff, rsp_data_in;

   logic [31:0] cur_va;
   logic [2:0]  cur_len;
   logic        fits_ent;
   logic        fits_dat;
   logic [31:0] q_word;
   logic [31:0] rd_mask;
   logic        more;
   logic        fault;
   logic        out_free;
   logic        wr_en;
   logic [2:0]  wr_len;
   logic [31:0] wr_word;
   logic [2:0]  n_clamp;
   logic [12:0] end_ofs;
   logic [7:0]  bank_q [4];

   assign cur_va = va0_ff + 32'(idx_ff);
   assign cur_len = split_ff ? 3'd1 : n_ff;
   assign fits_ent = ({2'b00, addr_ff} + 34'd4) <= MEM_SIZE;
   assign fits_dat = ({2'b00, addr_ff} + 34'(cur_len)) <= MEM_SIZE;
   assign more = split_ff && (({1'b0, idx_ff} + 3'd1) < n_ff);
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign rd_mask = (32'(1) << {cur_len, 3'b000}) - 32'd1;
   assign n_clamp = (req_data.nbytes > 3'd4) ? 3'd4 : req_data.nbytes;
   assign end_ofs = {1'b0, req_data.vaddr[11:0]} + 13'(n_clamp);

   for (genvar j = 0; j < 4; j++) begin : g_rd
      assign q_word[8*j +: 8] = bank_q[addr_ff[1:0] + 2'(j)];
   end

   for (genvar b = 0; b < 4; b++) begin : g_bank
      logic [1:0]               off;
      logic [MEM_ADDR_BITS-1:0] lane_addr;
      assign off = 2'(b) - addr_ff[1:0];
      assign lane_addr = addr_ff[MEM_ADDR_BITS-1:0] + MEM_ADDR_BITS'(off);
      tlpw_bank #(
         .ADDR_BITS(BANK_BITS)
      ) u_bank (
         .clock(clock),
         .we   (wr_en && ({1'b0, off} < wr_len)),
         .addr (lane_addr[MEM_ADDR_BITS-1:2]),
         .wd   (wr_word[{off, 3'b000} +: 8]),
         .q    (bank_q[b])
      );
   end

   always_comb begin
      wr_en = 1'b0;
      wr_len = 3'd4;
      wr_word = q_word;
      fault = 1'b0;
      cmd_in = cmd_ff;
      va0_in = va0_ff;
      n_in = n_ff;
      wdata_in = wdata_ff;
      split_in = split_ff;
      idx_in = idx_ff;
      addr_in = addr_ff;
      ent_in = ent_ff;
      acc_in = acc_ff;
      status_in = status_ff;
      paging_in = paging_ff;
      pdb_in = pdb_ff;
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (ctl.load) begin
         cmd_in = req_data.cmd;
         va0_in = req_data.vaddr;
         n_in = n_clamp;
         wdata_in = req_data.wdata;
         split_in = paging_ff && (end_ofs > 13'd4096);
         idx_in = 2'd0;
         acc_in = 32'd0;
         status_in = tlpw_pkg::ST_OK;
      end

      case (ctl.op)
         tlpw_pkg::OP_PHYS_ADDR: addr_in = va0_ff;
         tlpw_pkg::OP_DE_ADDR: addr_in = {pdb_ff, cur_va[31:22], 2'b00};
         tlpw_pkg::OP_RD_ENT: begin
            if (!fits_ent) begin
               fault = 1'b1;
               status_in = tlpw_pkg::ST_RANGE;
            end
         end
         tlpw_pkg::OP_DE_CHK: begin
            ent_in = q_word;
            if (!q_word[tlpw_pkg::ENT_PRESENT]) begin
               fault = 1'b1;
               status_in = tlpw_pkg::ST_NO_DIR;
            end else if (!q_word[tlpw_pkg::ENT_ACCESSED]) begin
               wr_en = 1'b1;
               wr_word[tlpw_pkg::ENT_ACCESSED] = 1'b1;
            end
         end
         tlpw_pkg::OP_TE_ADDR: addr_in = {ent_ff[31:12], cur_va[21:12], 2'b00};
         tlpw_pkg::OP_TE_CHK: begin
            ent_in = q_word;
            if (!q_word[tlpw_pkg::ENT_PRESENT]) begin
               fault = 1'b1;
               status_in = tlpw_pkg::ST_NO_TAB;
            end else begin
               wr_en = !q_word[tlpw_pkg::ENT_ACCESSED]
                  || (cmd_ff && !q_word[tlpw_pkg::ENT_DIRTY]);
               wr_word[tlpw_pkg::ENT_ACCESSED] = 1'b1;
               wr_word[tlpw_pkg::ENT_DIRTY] = q_word[tlpw_pkg::ENT_DIRTY] | cmd_ff;
            end
         end
         tlpw_pkg::OP_DATA_ADDR: addr_in = {ent_ff[31:12], cur_va[11:0]};
         tlpw_pkg::OP_DATA_ACC: begin
            wr_len = cur_len;
            wr_word = wdata_ff >> {idx_ff, 3'b000};
            if (!fits_dat) begin
               fault = 1'b1;
               status_in = tlpw_pkg::ST_RANGE;
            end else begin
               wr_en = cmd_ff;
            end
         end
         tlpw_pkg::OP_CAP: begin
            acc_in = acc_ff | ((q_word & rd_mask) << {idx_ff, 3'b000});
            if (more) begin
               idx_in = idx_ff + 2'd1;
            end
         end
         tlpw_pkg::OP_FIN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in.status = status_ff;
               rsp_data_in.rdata = (cmd_ff || (status_ff != tlpw_pkg::ST_OK)) ?
                  32'd0 : acc_ff;
            end
         end
         default: begin
         end
      endcase

      if (csr_valid) begin
         case (csr_index)
            tlpw_pkg::CSR_PAGING: paging_in = csr_wdata[0];
            tlpw_pkg::CSR_PDB: pdb_in = csr_wdata[31:12];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         paging_ff <= 1'b0;
         pdb_ff <= 20'd0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         paging_ff <= paging_in;
         pdb_ff <= pdb_in;
      end
      cmd_ff <= cmd_in;
      va0_ff <= va0_in;
      n_ff <= n_in;
      wdata_ff <= wdata_in;
      split_ff <= split_in;
      idx_ff <= idx_in;
      addr_ff <= addr_in;
      ent_ff <= ent_in;
      acc_ff <= acc_in;
      status_ff <= status_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;
   assign flags.zero_len = (n_ff == 3'd0);
   assign flags.paging = paging_ff;
   assign flags.fault = fault;
   assign flags.more = more;
   assign flags.out_free = out_free;

endmodule

/* rtl/tlpw_checker.sv */
// Port-level checker for the page walk MMU and its bind to the top level.
`include "two_level_page_walk_mmu_assert.svh"

module tlpw_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input tlpw_pkg::rsp_type rsp_data
);

   `TLPW_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall,
      rsp_valid && $stable(rsp_data))
   `TLPW_ASSERT_IMPL(a_fault_zero, clock, reset,
      rsp_valid && (rsp_data.status != tlpw_pkg::ST_OK), rsp_data.rdata == 32'd0)
   `TLPW_ASSERT_NEXT(a_busy_after_take, clock, reset, req_valid && !req_stall,
      req_stall)

endmodule

bind two_level_page_walk_mmu tlpw_checker u_tlpw_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_valid),
   .req_stall(req_stall),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp_data (rsp_data)
);
